// File: design/prr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prr_pkg: shared types and constants of the polyphase rational resampler
// The package holds the operation codes, the queue entry and the fixed
// field widths of the resampler.
// ----------------------------------------------------------------------------
package prr_pkg;

  localparam int SampleW = 16;
  localparam int TapW    = 18;
  localparam int AddrW   = 14;
  localparam int LW      = 9;
  localparam int MW      = 13;
  localparam int MLimit  = 4096;

  typedef enum logic {
    OP_SAMPLE = 1'b0,
    OP_TAP    = 1'b1
  } op_e;

  typedef enum logic {
    REG_INTERP = 1'b0,
    REG_DECIM  = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    op_e                        op;
    logic signed [SampleW-1:0]  sample;
    logic [AddrW-1:0]           addr;
    logic signed [TapW-1:0]     tap;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAC,
    ST_DRAIN,
    ST_OUT,
    ST_SKIP
  } back_state_e;

endpackage

// File: design/polyphase_rational_resampler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// polyphase_rational_resampler: L/M polyphase resampler
// Channel   | Signals                                    | Direction
// in        | in_valid_i, in_stall_o, operation_i, ...   | item in
// out       | out_valid_o, out_stall_i, sample_out_o ... | item out
// cfg       | cfg_we_i, cfg_index_i, cfg_data_i          | register write
// A tap write is done by the back end from idle; a sample shifts the history
// line, then the single shared MAC computes each output, then the phases past
// the cap are stepped over and the phase is rebased by L once.
// Reset clears history, phase and control; taps are kept undefined.
// Input stalls only when the 2-entry queue is full.
// ----------------------------------------------------------------------------
module polyphase_rational_resampler #(
  parameter int PHASE_LEN      = 64,
  parameter int MAX_BRANCHES   = 256,
  parameter int MAX_OUT_PER_IN = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_index_i,
  input  logic [12:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               operation_i,
  input  logic signed [15:0] sample_in_i,
  input  logic [13:0]        tap_address_i,
  input  logic signed [17:0] tap_value_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [15:0] sample_out_o,
  output logic               last_o
);
  import prr_pkg::*;

  logic [LW-1:0] interp_q;
  logic [MW-1:0] decim_q;
  logic          cmd_valid, cmd_pop;
  cmd_t          cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      interp_q <= LW'(1);
      decim_q  <= MW'(1);
    end else if (cfg_we_i) begin
      if (cfg_index_i == REG_INTERP) interp_q <= cfg_data_i[LW-1:0];
      else decim_q <= cfg_data_i;
    end
  end

  prr_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .operation_i, .sample_in_i,
    .tap_address_i, .tap_value_i,
    .cmd_valid_o(cmd_valid), .cmd_pop_i(cmd_pop), .cmd_o(cmd)
  );

  prr_back #(
    .PHASE_LEN(PHASE_LEN), .MAX_BRANCHES(MAX_BRANCHES), .MAX_OUT_PER_IN(MAX_OUT_PER_IN)
  ) u_back (
    .clk_i, .rst_ni, .cmd_valid_i(cmd_valid), .cmd_pop_o(cmd_pop), .cmd_i(cmd),
    .interp_factor_i(interp_q), .decim_factor_i(decim_q),
    .out_valid_o, .out_stall_i, .sample_out_o, .last_o
  );

endmodule

// File: design/prr_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prr_front: input stage and command queue
// Accepts items, tags them by operation and holds them in a short FIFO
// that the back end drains at its own pace.
// ----------------------------------------------------------------------------
module prr_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic                      operation_i,
  input  logic signed [15:0]        sample_in_i,
  input  logic [13:0]               tap_address_i,
  input  logic signed [17:0]        tap_value_i,
  output logic                      cmd_valid_o,
  input  logic                      cmd_pop_i,
  output prr_pkg::cmd_t             cmd_o
);
  import prr_pkg::*;

  cmd_t       fifo_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       push;
  cmd_t       cmd_in;

  assign in_stall_o  = (cnt_q == 2'd2);
  assign push        = in_valid_i && !in_stall_o;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = fifo_q[rd_ptr_q];

  always_comb begin
    cmd_in.op     = op_e'(operation_i);
    cmd_in.sample = sample_in_i;
    cmd_in.addr   = tap_address_i;
    cmd_in.tap    = tap_value_i;
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= cmd_in;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (cmd_pop_i) rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, cmd_pop_i};
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) cmd_pop_i |-> cmd_valid_o)
    else $error("pop from empty queue");
  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= 2'd2)
    else $error("queue count overflow");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !cmd_pop_i) |=> cnt_q == $past(cnt_q) + 2'd1)
    else $error("queue count not advanced on push");

endmodule

// File: design/prr_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prr_back: tap memory, history line and shared MAC
// Executes tap writes and sample items; each output is one branch dot
// product done one tap per cycle, then rounded and saturated.
// ----------------------------------------------------------------------------
module prr_back #(
  parameter int PHASE_LEN      = 64,
  parameter int MAX_BRANCHES   = 256,
  parameter int MAX_OUT_PER_IN = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cmd_valid_i,
  output logic                cmd_pop_o,
  input  prr_pkg::cmd_t       cmd_i,
  input  logic [8:0]          interp_factor_i,
  input  logic [12:0]         decim_factor_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic signed [15:0]  sample_out_o,
  output logic                last_o
);
  import prr_pkg::*;

  localparam int PosW   = $clog2(PHASE_LEN);
  localparam int BrW    = $clog2(MAX_BRANCHES);
  localparam int Depth  = MAX_BRANCHES * PHASE_LEN;
  localparam int DAddrW = $clog2(Depth);
  localparam int CntW   = $clog2(MAX_OUT_PER_IN + 1);
  localparam int AccW   = 34 + PosW + 1;
  localparam int PhW    = MW + 1;

  logic signed [TapW-1:0]    tap_mem [Depth];
  logic signed [SampleW-1:0] hist_q [PHASE_LEN];

  back_state_e state_q, state_d;
  logic [PhW-1:0]      phase_q;
  logic [PosW-1:0]     pos_q;
  logic [CntW-1:0]     cnt_q;
  logic signed [AccW-1:0] acc_q;
  logic signed [TapW-1:0] tap_rd_q;
  logic signed [SampleW-1:0] hist_rd_q;
  logic                rd_vld_q, rd_last_q;
  logic signed [SampleW+TapW-1:0] prod_q;
  logic                prod_vld_q, prod_last_q;
  logic signed [15:0]  res_q;
  logic                res_last_q, out_vld_q;

  logic [LW-1:0] l_eff;
  logic [MW-1:0] m_eff;
  logic          start_smp, tap_wr, more;
  logic [PhW-1:0] phase_nx;
  logic [DAddrW-1:0] rd_addr;
  logic signed [AccW-1:0] sum, rnd;
  logic signed [15:0] sat;

  always_comb begin
    l_eff = (interp_factor_i > LW'(MAX_BRANCHES)) ? LW'(MAX_BRANCHES) : interp_factor_i;
    m_eff = (decim_factor_i == '0) ? MW'(1) :
            (decim_factor_i > MW'(MLimit)) ? MW'(MLimit) : decim_factor_i;
  end

  assign tap_wr    = (state_q == ST_IDLE) && cmd_valid_i && (cmd_i.op == OP_TAP);
  assign start_smp = (state_q == ST_IDLE) && cmd_valid_i && (cmd_i.op == OP_SAMPLE);
  assign cmd_pop_o = tap_wr || start_smp;
  assign phase_nx  = phase_q + PhW'(m_eff);
  // another output after the current one when the next phase is still below L and the output cap is not yet reached
  assign more      = (phase_nx < PhW'(l_eff)) && (cnt_q < CntW'(MAX_OUT_PER_IN - 1));
  // branch * PHASE_LEN + position
  assign rd_addr   = DAddrW'(phase_q[BrW-1:0]) * DAddrW'(PHASE_LEN) + DAddrW'(pos_q);

  always_ff @(posedge clk_i) begin
    if (tap_wr && (int'(cmd_i.addr) < Depth)) begin
      tap_mem[DAddrW'(cmd_i.addr)] <= cmd_i.tap;
    end
    tap_rd_q  <= tap_mem[rd_addr];
    hist_rd_q <= hist_q[pos_q];
    prod_q    <= tap_rd_q * hist_rd_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < PHASE_LEN; i++) hist_q[i] <= '0;
    end else if (start_smp) begin
      for (int i = 0; i < PHASE_LEN - 1; i++) hist_q[i] <= hist_q[i+1];
      hist_q[PHASE_LEN-1] <= cmd_i.sample;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start_smp) state_d = (l_eff == '0 || phase_q >= PhW'(l_eff)) ? ST_IDLE : ST_MAC;
      end
      ST_MAC:   if (pos_q == PosW'(PHASE_LEN - 1)) state_d = ST_DRAIN;
      ST_DRAIN: if (prod_vld_q && prod_last_q) state_d = ST_OUT;
      ST_OUT:   if (!out_vld_q) state_d = more ? ST_MAC : ST_SKIP;
      ST_SKIP:  if (phase_q >= PhW'(l_eff)) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  assign sum = acc_q + AccW'(prod_q);
  assign rnd = (sum + AccW'(32768)) >>> 16;
  assign sat = (rnd > AccW'(32767)) ? 16'sh7fff :
               (rnd < -AccW'(32768)) ? -16'sh8000 : rnd[15:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      phase_q    <= '0;
      pos_q      <= '0;
      cnt_q      <= '0;
      acc_q      <= '0;
      rd_vld_q   <= 1'b0;
      rd_last_q  <= 1'b0;
      prod_vld_q <= 1'b0;
      prod_last_q<= 1'b0;
      out_vld_q  <= 1'b0;
      res_q      <= '0;
      res_last_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rd_vld_q    <= (state_q == ST_MAC);
      rd_last_q   <= (state_q == ST_MAC) && (pos_q == PosW'(PHASE_LEN - 1));
      prod_vld_q  <= rd_vld_q;
      prod_last_q <= rd_last_q;
      if (state_q == ST_MAC) begin
        pos_q <= (pos_q == PosW'(PHASE_LEN - 1)) ? '0 : pos_q + PosW'(1);
      end
      if (prod_vld_q) begin
        acc_q <= prod_last_q ? '0 : sum;
        if (prod_last_q) begin
          res_q      <= sat;
          res_last_q <= !more;
          out_vld_q  <= 1'b1;
        end
      end
      if (out_vld_q && !out_stall_i) out_vld_q <= 1'b0;
      if (start_smp) cnt_q <= '0;
      if (state_q == ST_OUT && !out_vld_q) begin
        cnt_q   <= cnt_q + CntW'(1);
        phase_q <= phase_nx;
      end else if (state_q == ST_SKIP) begin
        // step over phases past the cap, then rebase by L once
        phase_q <= (phase_q < PhW'(l_eff)) ? phase_q + PhW'(m_eff) : phase_q - PhW'(l_eff);
      end else if (start_smp && l_eff != '0 && phase_q >= PhW'(l_eff)) begin
        phase_q <= phase_q - PhW'(l_eff);
      end
    end
  end

  assign out_valid_o  = out_vld_q;
  assign sample_out_o = res_q;
  assign last_o       = res_last_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && out_stall_i |=> out_vld_q && $stable(res_q))
    else $error("output dropped under stall");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop_o |-> state_q == ST_IDLE)
    else $error("command taken while busy");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_MAC |-> !out_vld_q)
    else $error("MAC running with output pending");

endmodule
